// ===== rtl/fraction_sum_accumulator_defines.svh =====
// assertion macros for the fraction sum accumulator checker
// no dependencies; included by the checker file
`ifndef FRACTION_SUM_ACCUMULATOR_DEFINES_SVH
`define FRACTION_SUM_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FSA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fsa check failed");

// next-cycle implication, disabled during reset
`define FSA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fsa check failed");

`endif

// ===== rtl/fsa_pkg.sv =====
// shared types and constants for the fraction sum accumulator
// no dependencies; used by controller, datapath and top level
package fsa_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int OUT_WIDTH = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_GINIT,
        S_GCD,
        S_FIX,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic gcd_init;
        logic gcd_step;
        logic fix_step;
        logic div_init;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
        logic start;
        logic a_zero;
        logic k_zero;
    } t_stat;

endpackage

// ===== rtl/fraction_sum_accumulator.sv =====
// top level of the fraction sum accumulator: stream ports, controller and datapath
// depends on fsa_pkg, fsa_ctrl, fsa_datapath
//
// usage:
//   input stream takes one fraction per item: tdata holds numerator and
//   denominator, tuser holds the start flag. start replaces the running sum
//   with the reduced incoming fraction, otherwise the fraction is added.
//   output stream returns one item per input item with the reduced running
//   sum in tdata and overflow / bad input flags in tuser.
// sequencing:
//   one item at a time; the input is ready only while idle. a zero
//   denominator goes from the check straight to commit. otherwise the item runs
//   a shift-add multiply (start items skip it), gcd setup, the binary gcd loop
//   (data dependent), one restore step per common power of two, the bit-serial
//   dividers over IW bits and commit, IW = SUM_WIDTH + OPERAND_WIDTH + 1.
//   the result is valid from the edge that ends the commit cycle.
//   the gcd loop runs one shift or subtract per cycle until a reaches zero.
// reset: sum becomes 0/1, no result pending, input ready.
// stall: a finished result waits in the output register; the next item is
//   taken and computed meanwhile, and it finishes once the output frees up.
module fraction_sum_accumulator
    import fsa_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16,
    parameter int SUM_WIDTH     = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // numerator, denominator
    input  logic        i_s_tuser,   // start_req
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // sum_numerator, sum_denominator
    output logic [1:0]  o_m_tuser    // overflow, bad_input
);

    t_cmd  cmd;
    t_stat stat;

    fsa_ctrl #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .SUM_WIDTH     (SUM_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fsa_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .SUM_WIDTH     (SUM_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_numerator       (i_s_tdata[15:0]),
        .i_denominator     (i_s_tdata[31:16]),
        .i_start_req       (i_s_tuser),
        .o_sum_numerator   (o_m_tdata[31:0]),
        .o_sum_denominator (o_m_tdata[63:32]),
        .o_overflow        (o_m_tuser[0]),
        .o_bad_input       (o_m_tuser[1])
    );

endmodule

// ===== rtl/fsa_ctrl.sv =====
// controller state machine: sequences multiply, gcd, restore and divide phases
// depends on fsa_pkg; drives fsa_datapath through t_cmd
module fsa_ctrl
    import fsa_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16,
    parameter int SUM_WIDTH     = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    input  logic  i_m_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int IW = SUM_WIDTH + OPERAND_WIDTH + 1;
    localparam int CW = $clog2(IW);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        n_out_valid = (r_out_valid && !i_m_tready);
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.den_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.start) begin
                    n_state = S_GINIT;
                end else begin
                    n_cnt   = CW'(OPERAND_WIDTH - 1);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_GINIT;
                end
            end
            S_GINIT: begin
                o_cmd.gcd_init = 1'b1;
                n_state        = S_GCD;
            end
            S_GCD: begin
                if (i_stat.a_zero) begin
                    n_state = S_FIX;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_FIX: begin
                if (i_stat.k_zero) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = CW'(IW - 1);
                    n_state        = S_DIV;
                end else begin
                    o_cmd.fix_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

// ===== rtl/fsa_datapath.sv =====
// datapath: shift-add multiply, binary gcd, restoring dividers, sum and result registers
// depends on fsa_pkg; controlled by fsa_ctrl
module fsa_datapath
    import fsa_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16,
    parameter int SUM_WIDTH     = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [IN_WIDTH-1:0]  i_numerator,
    input  logic [IN_WIDTH-1:0]  i_denominator,
    input  logic                 i_start_req,
    output logic [OUT_WIDTH-1:0] o_sum_numerator,
    output logic [OUT_WIDTH-1:0] o_sum_denominator,
    output logic                 o_overflow,
    output logic                 o_bad_input
);

    localparam int OW = OPERAND_WIDTH;
    localparam int SW = SUM_WIDTH;
    localparam int IW = SW + OW + 1;
    localparam int KW = $clog2(IW);

    logic [OW-1:0]        r_n2, r_d2, r_mn, r_md;
    logic                 r_start;
    logic [IW-1:0]        r_acc_n, r_acc_d, r_a, r_b, r_qn, r_qd, r_rn, r_rd;
    logic [KW-1:0]        r_k;
    logic [SW-1:0]        r_sum_n, r_sum_d;
    logic [OUT_WIDTH-1:0] r_out_n, r_out_d;
    logic                 r_ovf, r_bad;

    logic [OW-1:0]        n_n2, n_d2, n_mn, n_md;
    logic                 n_start;
    logic [IW-1:0]        n_acc_n, n_acc_d, n_a, n_b, n_qn, n_qd, n_rn, n_rd;
    logic [KW-1:0]        n_k;
    logic [SW-1:0]        n_sum_n, n_sum_d;
    logic [OUT_WIDTH-1:0] n_out_n, n_out_d;
    logic                 n_ovf, n_bad;

    logic [OW+IN_WIDTH-1:0] num_ext, den_ext;
    logic [IW-1:0]          n1_w, d1_w, n2_w, d2_w;
    logic [IW:0]            rn_sh, rd_sh, g_w;
    logic                   too_wide;
    logic [SW+OUT_WIDTH-1:0] sum_n_ext, sum_d_ext;

    assign num_ext = {{OW{1'b0}}, i_numerator};
    assign den_ext = {{OW{1'b0}}, i_denominator};
    assign n1_w    = {{(OW+1){1'b0}}, r_sum_n};
    assign d1_w    = {{(OW+1){1'b0}}, r_sum_d};
    assign n2_w    = {{(SW+1){1'b0}}, r_n2};
    assign d2_w    = {{(SW+1){1'b0}}, r_d2};
    assign rn_sh   = {r_rn, r_qn[IW-1]};
    assign rd_sh   = {r_rd, r_qd[IW-1]};
    assign g_w     = {1'b0, r_b};
    assign too_wide = (r_qn[IW-1:SW] != '0) || (r_qd[IW-1:SW] != '0);

    assign o_stat.den_zero = (r_d2 == '0);
    assign o_stat.start    = r_start;
    assign o_stat.a_zero   = (r_a == '0);
    assign o_stat.k_zero   = (r_k == '0);

    always_comb begin
        n_n2 = r_n2;   n_d2 = r_d2;   n_mn = r_mn;   n_md = r_md;
        n_start = r_start;
        n_acc_n = r_acc_n;  n_acc_d = r_acc_d;
        n_a = r_a;  n_b = r_b;  n_k = r_k;
        n_qn = r_qn;  n_qd = r_qd;  n_rn = r_rn;  n_rd = r_rd;
        n_sum_n = r_sum_n;  n_sum_d = r_sum_d;
        n_out_n = r_out_n;  n_out_d = r_out_d;
        n_ovf = r_ovf;  n_bad = r_bad;
        sum_n_ext = '0;
        sum_d_ext = '0;

        if (i_cmd.load) begin
            n_n2    = num_ext[OW-1:0];
            n_d2    = den_ext[OW-1:0];
            n_mn    = num_ext[OW-1:0];
            n_md    = den_ext[OW-1:0];
            n_start = i_start_req;
            n_acc_n = '0;
            n_acc_d = '0;
        end

        // msb-first shift-add of n1*d2 + n2*d1 and d1*d2
        if (i_cmd.mul_step) begin
            n_acc_n = (r_acc_n << 1) + (r_md[OW-1] ? n1_w : '0) + (r_mn[OW-1] ? d1_w : '0);
            n_acc_d = (r_acc_d << 1) + (r_md[OW-1] ? d1_w : '0);
            n_mn    = r_mn << 1;
            n_md    = r_md << 1;
        end

        if (i_cmd.gcd_init) begin
            n_a  = r_start ? n2_w : r_acc_n;
            n_b  = r_start ? d2_w : r_acc_d;
            n_qn = n_a;
            n_qd = n_b;
            n_k  = '0;
        end

        // binary gcd, b stays nonzero
        if (i_cmd.gcd_step) begin
            if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a >= r_b) begin
                n_a = r_a - r_b;
            end else begin
                n_b = r_b - r_a;
            end
        end

        // put back common powers of two
        if (i_cmd.fix_step) begin
            n_b = r_b << 1;
            n_k = r_k - 1'b1;
        end

        if (i_cmd.div_init) begin
            n_rn = '0;
            n_rd = '0;
        end

        // restoring division of both terms by g
        if (i_cmd.div_step) begin
            if (rn_sh >= g_w) begin
                n_rn = IW'(rn_sh - g_w);
                n_qn = {r_qn[IW-2:0], 1'b1};
            end else begin
                n_rn = rn_sh[IW-1:0];
                n_qn = {r_qn[IW-2:0], 1'b0};
            end
            if (rd_sh >= g_w) begin
                n_rd = IW'(rd_sh - g_w);
                n_qd = {r_qd[IW-2:0], 1'b1};
            end else begin
                n_rd = rd_sh[IW-1:0];
                n_qd = {r_qd[IW-2:0], 1'b0};
            end
        end

        if (i_cmd.commit) begin
            n_bad = 1'b0;
            n_ovf = 1'b0;
            if (r_d2 == '0) begin
                n_bad = 1'b1;
            end else if (too_wide) begin
                n_ovf = 1'b1;
            end else begin
                n_sum_n = r_qn[SW-1:0];
                n_sum_d = r_qd[SW-1:0];
            end
            sum_n_ext = {{OUT_WIDTH{1'b0}}, n_sum_n};
            sum_d_ext = {{OUT_WIDTH{1'b0}}, n_sum_d};
            n_out_n   = sum_n_ext[OUT_WIDTH-1:0];
            n_out_d   = sum_d_ext[OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_n <= '0;
            r_sum_d <= SW'(1);
        end else begin
            r_sum_n <= n_sum_n;
            r_sum_d <= n_sum_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n2 <= n_n2;   r_d2 <= n_d2;   r_mn <= n_mn;   r_md <= n_md;
        r_start <= n_start;
        r_acc_n <= n_acc_n;  r_acc_d <= n_acc_d;
        r_a <= n_a;  r_b <= n_b;  r_k <= n_k;
        r_qn <= n_qn;  r_qd <= n_qd;  r_rn <= n_rn;  r_rd <= n_rd;
        r_out_n <= n_out_n;  r_out_d <= n_out_d;
        r_ovf <= n_ovf;  r_bad <= n_bad;
    end

    assign o_sum_numerator   = r_out_n;
    assign o_sum_denominator = r_out_d;
    assign o_overflow        = r_ovf;
    assign o_bad_input       = r_bad;

endmodule

// ===== rtl/fsa_checker.sv =====
// port-level checker for the fraction sum accumulator, bound to the top level
// depends on fraction_sum_accumulator_defines.svh
`include "fraction_sum_accumulator_defines.svh"

module fsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] i_m_tdata,
    input logic [1:0]  i_m_tuser
);

    // result held while stalled
    `FSA_ASSERT_NXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid)

    // stalled result keeps its payload
    `FSA_ASSERT_NXT(a_out_stable, i_m_tvalid && !i_m_tready,
                    $stable(i_m_tdata) && $stable(i_m_tuser))

    // overflow and bad input never flagged together
    `FSA_ASSERT_IMP(a_flags_excl, i_m_tvalid, !(i_m_tuser[0] && i_m_tuser[1]))

    // one item in flight: ready drops after an item is taken
    `FSA_ASSERT_NXT(a_busy_after_take, i_s_tvalid && i_s_tready, !i_s_tready)

endmodule

bind fraction_sum_accumulator fsa_checker u_fsa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);

// ===== tb/sv/fraction_sum_accumulator_test.sv =====
// stream testbench for the fraction sum accumulator: directed and random fraction sequences
// predicts each running sum in lowest terms and checks every output item in order
// depends on fsa_pkg and fraction_sum_accumulator
`timescale 1ns / 100ps

module fraction_sum_accumulator_test;
    import fsa_pkg::*;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] num;
        logic [OUT_WIDTH-1:0] den;
        logic                 ovf;
        logic                 bad;
    } sum_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // numerator, denominator
    logic        s_tuser = 1'b0; // start_req
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [63:0] m_tdata;        // sum_numerator, sum_denominator
    logic [1:0]  m_tuser;        // overflow, bad_input

    logic                 idle_en = 1'b1;
    int                   stall_left = 0;
    int                   error_count = 0;
    logic [OUT_WIDTH-1:0] acc_num = '0;
    logic [OUT_WIDTH-1:0] acc_den = 1;
    sum_item_t            expected_sums[$];

    fraction_sum_accumulator u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic sum_item_t add_to_running_sum(logic [IN_WIDTH-1:0] n,
                                                     logic [IN_WIDTH-1:0] d, logic st);
        sum_item_t   r;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] t;
        r.ovf = 1'b0;
        r.bad = 1'b0;
        if (d == 0) begin
            r.bad = 1'b1;
        end else begin
            if (st) begin
                num = 64'(n);
                den = 64'(d);
            end else begin
                num = 64'(acc_num) * 64'(d) + 64'(n) * 64'(acc_den);
                den = 64'(acc_den) * 64'(d);
            end
            // euclid
            a = num;
            b = den;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            num = num / a;
            den = den / a;
            if (num[63:OUT_WIDTH] != 0 || den[63:OUT_WIDTH] != 0) begin
                r.ovf = 1'b1;
            end else begin
                acc_num = num[OUT_WIDTH-1:0];
                acc_den = den[OUT_WIDTH-1:0];
            end
        end
        r.num = acc_num;
        r.den = acc_den;
        return r;
    endfunction

    function automatic logic [IN_WIDTH-1:0] pick_operand(bit allow_zero);
        case ($urandom_range(0, 6))
            0: return IN_WIDTH'($urandom_range(1, 16));
            1: return '1;
            2: return IN_WIDTH'(1) << $urandom_range(0, IN_WIDTH - 1);
            3, 4: return IN_WIDTH'($urandom_range(1, 65535));
            5: return allow_zero ? '0 : IN_WIDTH'($urandom_range(1, 255));
            default: return IN_WIDTH'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic void check_field(string name, logic [OUT_WIDTH-1:0] exp_v,
                                        logic [OUT_WIDTH-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    task automatic send_fraction(logic [IN_WIDTH-1:0] n, logic [IN_WIDTH-1:0] d, logic st);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, n};
        s_tuser  <= st;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_sums.push_back(add_to_running_sum(n, d, st));
    endtask

    task automatic wait_for_sums();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_sums.size() != 0) @(posedge clk);
    endtask

    // result checker and output stall generator
    always @(posedge clk) begin
        sum_item_t exp_r;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_sums.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %0h / %0h",
                         $time, m_tdata[31:0], m_tdata[63:32]);
                error_count++;
            end else begin
                exp_r = expected_sums.pop_front();
                check_field("sum_numerator", exp_r.num, m_tdata[31:0]);
                check_field("sum_denominator", exp_r.den, m_tdata[63:32]);
                check_field("overflow", 32'(exp_r.ovf), 32'(m_tuser[0]));
                check_field("bad_input", 32'(exp_r.bad), 32'(m_tuser[1]));
            end
        end
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic test_directed_cases();
        send_fraction(16'd3, 16'd6, 1'b0);           // add before any start
        send_fraction(16'd5, 16'd0, 1'b1);           // zero denominator on start
        send_fraction(16'd7, 16'd0, 1'b0);
        send_fraction(16'd0, 16'd0, 1'b0);
        send_fraction(16'd0, 16'd5, 1'b1);           // zero numerator
        send_fraction(16'hFFFF, 16'hFFFF, 1'b1);
        send_fraction(16'hFFFF, 16'd1, 1'b0);
        send_fraction(16'd12, 16'd18, 1'b1);
        send_fraction(16'd1, 16'd3, 1'b0);
        send_fraction(16'hFFFF, 16'hFFFF, 1'b0);
        send_fraction(16'd1, 16'd65521, 1'b1);       // denominator grows past sum width
        send_fraction(16'd1, 16'd65519, 1'b0);
        send_fraction(16'd1, 16'd65497, 1'b0);
        send_fraction(16'd0, 16'd1, 1'b0);
        send_fraction(16'hFFFF, 16'd1, 1'b1);        // numerator grows over repeated adds
        repeat (4) send_fraction(16'hFFFF, 16'd1, 1'b0);
        send_fraction(16'hFFFF, 16'd1, 1'b1);
        send_fraction(16'd65534, 16'd65535, 1'b0);
        send_fraction(16'd65533, 16'd65531, 1'b0);
        send_fraction(16'hAAAA, 16'h5555, 1'b1);
        send_fraction(16'h5555, 16'hAAAA, 1'b0);
        wait_for_sums();
    endtask

    task automatic test_random_chains(int items);
        int   sent;
        int   len;
        bit   open_chain;
        logic [IN_WIDTH-1:0] d;
        sent = 0;
        while (sent < items) begin
            idle_en    <= ($urandom_range(0, 3) != 0);
            open_chain = ($urandom_range(0, 9) != 0);
            len        = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                d = ($urandom_range(0, 19) == 0) ? '0 : pick_operand(1'b0);
                send_fraction(pick_operand(1'b1), d, (k == 0) && open_chain);
                sent++;
            end
            if ($urandom_range(0, 9) == 0) wait_for_sums();
        end
    endtask

    task automatic test_drain_pause();
        idle_en <= 1'b1;
        for (int r = 0; r < 3; r++) begin
            send_fraction(pick_operand(1'b1), pick_operand(1'b0), 1'b1);
            repeat (3) send_fraction(pick_operand(1'b1), pick_operand(1'b0), 1'b0);
            wait_for_sums();
        end
    endtask

    task automatic test_back_to_back(int items);
        idle_en <= 1'b0;
        for (int k = 0; k < items; k++) begin
            send_fraction(pick_operand(1'b1),
                          ($urandom_range(0, 19) == 0) ? '0 : pick_operand(1'b0),
                          ($urandom_range(0, 4) == 0));
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_chains(400);
        test_drain_pause();
        test_back_to_back(110);
        wait_for_sums();
        repeat (400) @(posedge clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
